/* rtl/mdg_pkg.sv */
// Shared types, constants and helpers for the maze generator.
// Used by every module of the block except mdg_ram; depends on nothing.
`default_nettype none

package mdg_pkg;

    localparam int GRID_HEIGHT = 11;
    localparam int GRID_WIDTH  = 11;
    localparam int ROW_W       = 4;
    localparam int COL_W       = 4;
    localparam int SEED_W      = 16;

    localparam int CELLS       = GRID_HEIGHT * GRID_WIDTH;
    localparam int CELL_W      = $clog2(CELLS);
    localparam int STACK_SLOTS = ((GRID_HEIGHT - 1) / 2) * ((GRID_WIDTH - 1) / 2);
    localparam int SP_W        = $clog2(STACK_SLOTS);
    localparam int DEPTH_W     = $clog2(STACK_SLOTS + 1);

    localparam logic [SEED_W-1:0] LFSR_TAPS = 16'hB400;
    localparam logic [SEED_W-1:0] LFSR_ONE  = 16'h0001;

    localparam logic [CELL_W-1:0] ENTRY_ADDR = CELL_W'(GRID_WIDTH);
    localparam logic [CELL_W-1:0] EXIT_ADDR  =
        CELL_W'((GRID_HEIGHT - 2) * GRID_WIDTH + GRID_WIDTH - 1);

    typedef logic [1:0] dir_t;

    localparam dir_t DIR_RIGHT = 2'd0;
    localparam dir_t DIR_LEFT  = 2'd1;
    localparam dir_t DIR_DOWN  = 2'd2;
    localparam dir_t DIR_UP    = 2'd3;

    typedef struct packed {
        logic              req_type;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [SEED_W-1:0] seed;
    } req_word_t;

    typedef struct packed {
        logic cell_open;
        logic status;
    } rsp_word_t;

    // one frame of the walk: cell, shuffled directions, next direction slot
    typedef struct packed {
        logic [ROW_W-1:0] r;
        logic [COL_W-1:0] c;
        dir_t [3:0]       dirs;
        logic [2:0]       nxt;
    } frame_t;

    localparam int FRAME_W = $bits(frame_t);

    typedef enum logic [3:0] {
        OP_NOP,
        OP_WAIT_IN,
        OP_EMIT_READ,
        OP_EMIT_ERR,
        OP_SEED,
        OP_CLEAR,
        OP_MARK,
        OP_SWAP,
        OP_CAND,
        OP_PROBE,
        OP_CARVE,
        OP_POP,
        OP_LOAD,
        OP_OPEN_IN,
        OP_OPEN_OUT,
        OP_EMIT_OK
    } op_t;

    typedef enum logic [3:0] {
        C_ALWAYS,
        C_NO_ACC,
        C_REQ_READ,
        C_BAD_START,
        C_CLR_MORE,
        C_SHUF_MORE,
        C_NXT_DONE,
        C_OUTSIDE,
        C_CELL_OPEN,
        C_DEPTH_ONE
    } cond_t;

    typedef enum logic [4:0] {
        S_IDLE     = 5'd0,
        S_DISP     = 5'd1,
        S_CHECK    = 5'd2,
        S_SEED     = 5'd3,
        S_CLEAR    = 5'd4,
        S_ENTER    = 5'd5,
        S_SHUF     = 5'd6,
        S_LOOP     = 5'd7,
        S_CAND     = 5'd8,
        S_PROBE    = 5'd9,
        S_TEST     = 5'd10,
        S_CARVE    = 5'd11,
        S_POP      = 5'd12,
        S_LOAD     = 5'd13,
        S_OPEN_IN  = 5'd14,
        S_OPEN_OUT = 5'd15,
        S_DONE     = 5'd16,
        S_INIT     = 5'd17,
        S_INIT_END = 5'd18
    } step_t;

    // control word: datapath action, jump condition, hold-for-output, jump target
    typedef struct packed {
        op_t   op;
        cond_t cond;
        logic  wait_out;
        step_t target;
    } uword_t;

    typedef struct packed {
        logic in_acc;
        logic req_read;
        logic bad_start;
        logic clr_more;
        logic shuf_more;
        logic nxt_done;
        logic outside;
        logic cell_open;
        logic depth_one;
        logic out_busy;
    } flags_t;

    function automatic logic [CELL_W-1:0] cell_addr(input logic [ROW_W:0] r,
                                                    input logic [COL_W:0] c);
        cell_addr = CELL_W'(r) * CELL_W'(GRID_WIDTH) + CELL_W'(c);
    endfunction

    // Galois shift right; the draw is the low two bits of the new value
    function automatic logic [SEED_W-1:0] lfsr_step(input logic [SEED_W-1:0] v);
        lfsr_step = v[0] ? ((v >> 1) ^ LFSR_TAPS) : (v >> 1);
    endfunction

endpackage

`default_nettype wire

/* rtl/maze_dfs_generator_top.sv */
// Maze generator: a depth-first backtracker over an 11x11 grid held in a one-bit RAM,
// driven by a microcoded sequencer. A read word is accepted, then a dispatch step sees
// the registered RAM data and registers the result. A rejected generate word ends at
// the check step, which registers the error result. A good generate word runs accept,
// dispatch, check and seed steps, a clear sweep of all 121 cells, then per cell a mark,
// four shuffle draws, four neighbor probes (loop, candidate and probe steps, then test
// if inside the border and carve if still a wall) and a pop, then two steps to open
// entrance and exit and one result step. The sequencer runs one microcode step per
// cycle unless a result step holds. After reset the block sweeps the grid to walls
// before it takes its first word. A finished result waits in an output register while
// the next word is taken; a new result step stalls while it waits.
// Depends on mdg_pkg, mdg_useq, mdg_dpath and mdg_ram.
`default_nettype none

module maze_dfs_generator_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_ready,
    input  wire mdg_pkg::req_word_t req,
    output logic                    rsp_valid,
    input  wire logic               rsp_ready,
    output mdg_pkg::rsp_word_t      rsp
);

    mdg_pkg::uword_t ctrl;
    mdg_pkg::flags_t flags;

    mdg_useq u_useq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    mdg_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .flags     (flags),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

/* rtl/mdg_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// Standalone; no package needed.
`default_nettype none

module mdg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/mdg_useq.sv */
// Microcode sequencer: step counter, control ROM and conditional jumps.
// Depends on mdg_pkg.
`default_nettype none

module mdg_useq (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire mdg_pkg::flags_t flags,
    output mdg_pkg::uword_t      ctrl
);

    mdg_pkg::step_t  pc_reg;
    mdg_pkg::step_t  pc_next;
    mdg_pkg::uword_t uw;
    logic            cond_hit;

    // control ROM
    always_comb
    begin
        unique case (pc_reg)
            mdg_pkg::S_IDLE:
                uw = '{mdg_pkg::OP_WAIT_IN, mdg_pkg::C_NO_ACC, 1'b0, mdg_pkg::S_IDLE};
            mdg_pkg::S_DISP:
                uw = '{mdg_pkg::OP_EMIT_READ, mdg_pkg::C_REQ_READ, 1'b1, mdg_pkg::S_IDLE};
            mdg_pkg::S_CHECK:
                uw = '{mdg_pkg::OP_EMIT_ERR, mdg_pkg::C_BAD_START, 1'b1, mdg_pkg::S_IDLE};
            mdg_pkg::S_SEED:
                uw = '{mdg_pkg::OP_SEED, mdg_pkg::C_ALWAYS, 1'b0, mdg_pkg::S_CLEAR};
            mdg_pkg::S_CLEAR:
                uw = '{mdg_pkg::OP_CLEAR, mdg_pkg::C_CLR_MORE, 1'b0, mdg_pkg::S_CLEAR};
            mdg_pkg::S_ENTER:
                uw = '{mdg_pkg::OP_MARK, mdg_pkg::C_ALWAYS, 1'b0, mdg_pkg::S_SHUF};
            mdg_pkg::S_SHUF:
                uw = '{mdg_pkg::OP_SWAP, mdg_pkg::C_SHUF_MORE, 1'b0, mdg_pkg::S_SHUF};
            mdg_pkg::S_LOOP:
                uw = '{mdg_pkg::OP_NOP, mdg_pkg::C_NXT_DONE, 1'b0, mdg_pkg::S_POP};
            mdg_pkg::S_CAND:
                uw = '{mdg_pkg::OP_CAND, mdg_pkg::C_ALWAYS, 1'b0, mdg_pkg::S_PROBE};
            mdg_pkg::S_PROBE:
                uw = '{mdg_pkg::OP_PROBE, mdg_pkg::C_OUTSIDE, 1'b0, mdg_pkg::S_LOOP};
            mdg_pkg::S_TEST:
                uw = '{mdg_pkg::OP_NOP, mdg_pkg::C_CELL_OPEN, 1'b0, mdg_pkg::S_LOOP};
            mdg_pkg::S_CARVE:
                uw = '{mdg_pkg::OP_CARVE, mdg_pkg::C_ALWAYS, 1'b0, mdg_pkg::S_ENTER};
            mdg_pkg::S_POP:
                uw = '{mdg_pkg::OP_POP, mdg_pkg::C_DEPTH_ONE, 1'b0, mdg_pkg::S_OPEN_IN};
            mdg_pkg::S_LOAD:
                uw = '{mdg_pkg::OP_LOAD, mdg_pkg::C_ALWAYS, 1'b0, mdg_pkg::S_LOOP};
            mdg_pkg::S_OPEN_IN:
                uw = '{mdg_pkg::OP_OPEN_IN, mdg_pkg::C_ALWAYS, 1'b0, mdg_pkg::S_OPEN_OUT};
            mdg_pkg::S_OPEN_OUT:
                uw = '{mdg_pkg::OP_OPEN_OUT, mdg_pkg::C_ALWAYS, 1'b0, mdg_pkg::S_DONE};
            mdg_pkg::S_DONE:
                uw = '{mdg_pkg::OP_EMIT_OK, mdg_pkg::C_ALWAYS, 1'b1, mdg_pkg::S_IDLE};
            mdg_pkg::S_INIT:
                uw = '{mdg_pkg::OP_CLEAR, mdg_pkg::C_CLR_MORE, 1'b0, mdg_pkg::S_INIT};
            mdg_pkg::S_INIT_END:
                uw = '{mdg_pkg::OP_NOP, mdg_pkg::C_ALWAYS, 1'b0, mdg_pkg::S_IDLE};
            default:
                uw = '{mdg_pkg::OP_NOP, mdg_pkg::C_ALWAYS, 1'b0, mdg_pkg::S_IDLE};
        endcase
    end

    always_comb
    begin
        case (uw.cond)
            mdg_pkg::C_ALWAYS:    cond_hit = 1'b1;
            mdg_pkg::C_NO_ACC:    cond_hit = !flags.in_acc;
            mdg_pkg::C_REQ_READ:  cond_hit = flags.req_read;
            mdg_pkg::C_BAD_START: cond_hit = flags.bad_start;
            mdg_pkg::C_CLR_MORE:  cond_hit = flags.clr_more;
            mdg_pkg::C_SHUF_MORE: cond_hit = flags.shuf_more;
            mdg_pkg::C_NXT_DONE:  cond_hit = flags.nxt_done;
            mdg_pkg::C_OUTSIDE:   cond_hit = flags.outside;
            mdg_pkg::C_CELL_OPEN: cond_hit = flags.cell_open;
            mdg_pkg::C_DEPTH_ONE: cond_hit = flags.depth_one;
            default:              cond_hit = 1'b0;
        endcase
    end

    always_comb
    begin
        if (uw.wait_out && flags.out_busy)
        begin
            pc_next = pc_reg;
        end
        else if (cond_hit)
        begin
            pc_next = uw.target;
        end
        else
        begin
            pc_next = mdg_pkg::step_t'(pc_reg + 5'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= mdg_pkg::S_INIT;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    assign ctrl = uw;

endmodule

`default_nettype wire

/* rtl/mdg_dpath.sv */
// Datapath: request latch, LFSR, current frame, grid and stack RAMs, result register.
// Depends on mdg_pkg and mdg_ram.
`default_nettype none

module mdg_dpath (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire mdg_pkg::uword_t    ctrl,
    output mdg_pkg::flags_t         flags,
    input  wire logic               req_valid,
    output logic                    req_ready,
    input  wire mdg_pkg::req_word_t req,
    output logic                    rsp_valid,
    input  wire logic               rsp_ready,
    output mdg_pkg::rsp_word_t      rsp
);

    localparam int RW = mdg_pkg::ROW_W;
    localparam int CW = mdg_pkg::COL_W;

    mdg_pkg::req_word_t         req_reg;
    mdg_pkg::frame_t            cur_reg,   cur_next;
    logic [mdg_pkg::SEED_W-1:0] lfsr_reg,  lfsr_next;
    logic [mdg_pkg::DEPTH_W-1:0] depth_reg, depth_next;
    logic [mdg_pkg::CELL_W-1:0] clr_reg,   clr_next;
    logic [1:0]                 shuf_reg,  shuf_next;
    logic [RW:0]                nr_reg,    nr_next;
    logic [CW:0]                nc_reg,    nc_next;
    logic                       cin_reg,   cin_next;
    logic                       rsp_valid_reg, rsp_valid_next;
    mdg_pkg::rsp_word_t         rsp_reg,   rsp_next;

    logic                       acc;
    logic                       out_busy;
    logic                       in_range_in, in_range_reg;
    logic                       bad_start;

    logic                       g_we;
    logic [mdg_pkg::CELL_W-1:0] g_waddr, g_raddr;
    logic                       g_wdata, g_rdata;
    logic                       s_we;
    logic [mdg_pkg::SP_W-1:0]   s_waddr, s_raddr;
    mdg_pkg::frame_t            s_rdata;

    logic [mdg_pkg::SEED_W-1:0] lfsr_adv;
    logic [1:0]                 jsel;
    mdg_pkg::dir_t              dsel;
    logic [RW+1:0]              mid_r_sum;
    logic [CW+1:0]              mid_c_sum;
    logic                       emit;
    mdg_pkg::rsp_word_t         emit_word;

    assign req_ready = (ctrl.op == mdg_pkg::OP_WAIT_IN);
    assign acc       = req_valid && req_ready;
    assign out_busy  = rsp_valid_reg && !rsp_ready;

    assign in_range_in  = (req.row < RW'(mdg_pkg::GRID_HEIGHT))
                       && (req.col < CW'(mdg_pkg::GRID_WIDTH));
    assign in_range_reg = (req_reg.row < RW'(mdg_pkg::GRID_HEIGHT))
                       && (req_reg.col < CW'(mdg_pkg::GRID_WIDTH));
    // odd implies nonzero, so only the upper bound needs a compare
    assign bad_start = !(req_reg.row[0] && req_reg.col[0]
                      && (req_reg.row <= RW'(mdg_pkg::GRID_HEIGHT - 2))
                      && (req_reg.col <= CW'(mdg_pkg::GRID_WIDTH - 2)));

    assign lfsr_adv  = mdg_pkg::lfsr_step(lfsr_reg);
    assign jsel      = lfsr_adv[1:0];
    assign dsel      = cur_reg.dirs[cur_reg.nxt[1:0]];
    assign mid_r_sum = {2'b00, cur_reg.r} + {1'b0, nr_reg};
    assign mid_c_sum = {2'b00, cur_reg.c} + {1'b0, nc_reg};

    always_comb
    begin
        flags.in_acc    = acc;
        flags.req_read  = req_reg.req_type;
        flags.bad_start = bad_start;
        flags.clr_more  = (clr_reg != mdg_pkg::CELL_W'(mdg_pkg::CELLS - 1));
        flags.shuf_more = (shuf_reg != 2'd3);
        flags.nxt_done  = cur_reg.nxt[2];
        flags.outside   = !cin_reg;
        flags.cell_open = g_rdata;
        flags.depth_one = (depth_reg == mdg_pkg::DEPTH_W'(1));
        flags.out_busy  = out_busy;
    end

    // grid read address
    always_comb
    begin
        case (ctrl.op)
            mdg_pkg::OP_WAIT_IN:
                g_raddr = in_range_in ? mdg_pkg::cell_addr({1'b0, req.row}, {1'b0, req.col})
                                      : '0;
            mdg_pkg::OP_EMIT_READ:
                g_raddr = in_range_reg
                        ? mdg_pkg::cell_addr({1'b0, req_reg.row}, {1'b0, req_reg.col})
                        : '0;
            mdg_pkg::OP_PROBE:
                g_raddr = cin_reg ? mdg_pkg::cell_addr(nr_reg, nc_reg) : '0;
            default:
                g_raddr = '0;
        endcase
    end

    // grid write port and stack ports
    always_comb
    begin
        g_we    = 1'b0;
        g_waddr = '0;
        g_wdata = 1'b1;
        s_we    = 1'b0;
        s_waddr = mdg_pkg::SP_W'(depth_reg - mdg_pkg::DEPTH_W'(1));
        s_raddr = (depth_reg >= mdg_pkg::DEPTH_W'(2))
                ? mdg_pkg::SP_W'(depth_reg - mdg_pkg::DEPTH_W'(2)) : '0;
        unique case (ctrl.op)
            mdg_pkg::OP_CLEAR:
            begin
                g_we    = 1'b1;
                g_waddr = clr_reg;
                g_wdata = 1'b0;
            end
            mdg_pkg::OP_MARK:
            begin
                g_we    = 1'b1;
                g_waddr = mdg_pkg::cell_addr({1'b0, cur_reg.r}, {1'b0, cur_reg.c});
            end
            mdg_pkg::OP_CARVE:
            begin
                g_we    = 1'b1;
                g_waddr = mdg_pkg::cell_addr(mid_r_sum[RW+1:1], mid_c_sum[CW+1:1]);
                s_we    = 1'b1;
            end
            mdg_pkg::OP_OPEN_IN:
            begin
                g_we    = 1'b1;
                g_waddr = mdg_pkg::ENTRY_ADDR;
            end
            mdg_pkg::OP_OPEN_OUT:
            begin
                g_we    = 1'b1;
                g_waddr = mdg_pkg::EXIT_ADDR;
            end
            default:
            begin
                g_we = 1'b0;
            end
        endcase
    end

    // register updates
    always_comb
    begin
        cur_next   = cur_reg;
        lfsr_next  = lfsr_reg;
        depth_next = depth_reg;
        clr_next   = clr_reg;
        shuf_next  = shuf_reg;
        nr_next    = nr_reg;
        nc_next    = nc_reg;
        cin_next   = cin_reg;
        unique case (ctrl.op)
            mdg_pkg::OP_SEED:
            begin
                lfsr_next  = (req_reg.seed == '0) ? mdg_pkg::LFSR_ONE : req_reg.seed;
                clr_next   = '0;
                depth_next = '0;
                cur_next.r = req_reg.row;
                cur_next.c = req_reg.col;
            end
            mdg_pkg::OP_CLEAR:
            begin
                clr_next = clr_reg + mdg_pkg::CELL_W'(1);
            end
            mdg_pkg::OP_MARK:
            begin
                cur_next.dirs = {mdg_pkg::DIR_UP, mdg_pkg::DIR_DOWN,
                                 mdg_pkg::DIR_LEFT, mdg_pkg::DIR_RIGHT};
                cur_next.nxt  = 3'd0;
                shuf_next     = 2'd0;
                depth_next    = depth_reg + mdg_pkg::DEPTH_W'(1);
            end
            mdg_pkg::OP_SWAP:
            begin
                lfsr_next                = lfsr_adv;
                cur_next.dirs[shuf_reg]  = cur_reg.dirs[jsel];
                cur_next.dirs[jsel]      = cur_reg.dirs[shuf_reg];
                shuf_next                = shuf_reg + 2'd1;
            end
            mdg_pkg::OP_CAND:
            begin
                nr_next = {1'b0, cur_reg.r};
                nc_next = {1'b0, cur_reg.c};
                case (dsel)
                    mdg_pkg::DIR_RIGHT: nc_next = {1'b0, cur_reg.c} + (CW+1)'(2);
                    mdg_pkg::DIR_LEFT:  nc_next = {1'b0, cur_reg.c} - (CW+1)'(2);
                    mdg_pkg::DIR_DOWN:  nr_next = {1'b0, cur_reg.r} + (RW+1)'(2);
                    default:            nr_next = {1'b0, cur_reg.r} - (RW+1)'(2);
                endcase
                // an underflow wraps high and fails the upper bound
                cin_next = (nr_next != '0) && (nr_next < (RW+1)'(mdg_pkg::GRID_HEIGHT - 1))
                        && (nc_next != '0) && (nc_next < (CW+1)'(mdg_pkg::GRID_WIDTH - 1));
                cur_next.nxt = cur_reg.nxt + 3'd1;
            end
            mdg_pkg::OP_CARVE:
            begin
                cur_next.r = nr_reg[RW-1:0];
                cur_next.c = nc_reg[CW-1:0];
            end
            mdg_pkg::OP_POP:
            begin
                depth_next = depth_reg - mdg_pkg::DEPTH_W'(1);
            end
            mdg_pkg::OP_LOAD:
            begin
                cur_next = s_rdata;
            end
            default:
            begin
                cur_next = cur_reg;
            end
        endcase
    end

    // result word
    always_comb
    begin
        emit      = 1'b0;
        emit_word = '{cell_open: 1'b0, status: 1'b0};
        unique case (ctrl.op)
            mdg_pkg::OP_EMIT_READ:
            begin
                emit      = req_reg.req_type;
                emit_word = '{cell_open: in_range_reg && g_rdata, status: !in_range_reg};
            end
            mdg_pkg::OP_EMIT_ERR:
            begin
                emit      = bad_start;
                emit_word = '{cell_open: 1'b0, status: 1'b1};
            end
            mdg_pkg::OP_EMIT_OK:
            begin
                emit = 1'b1;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        if (emit && !out_busy)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = emit_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lfsr_reg      <= mdg_pkg::LFSR_ONE;
            depth_reg     <= '0;
            clr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            lfsr_reg      <= lfsr_next;
            depth_reg     <= depth_next;
            clr_reg       <= clr_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            req_reg <= req;
        end
        cur_reg  <= cur_next;
        shuf_reg <= shuf_next;
        nr_reg   <= nr_next;
        nc_reg   <= nc_next;
        cin_reg  <= cin_next;
        rsp_reg  <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    mdg_ram #(
        .WIDTH (1),
        .DEPTH (mdg_pkg::CELLS)
    ) u_grid (
        .clk   (clk),
        .we    (g_we),
        .waddr (g_waddr),
        .wdata (g_wdata),
        .raddr (g_raddr),
        .rdata (g_rdata)
    );

    mdg_ram #(
        .WIDTH (mdg_pkg::FRAME_W),
        .DEPTH (mdg_pkg::STACK_SLOTS)
    ) u_stack (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (cur_reg),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

endmodule

`default_nettype wire

/* rtl/mdg_checker.sv */
// Port-level checks for the maze generator, bound to the top level.
// Depends on mdg_pkg and maze_dfs_generator_top.
`default_nettype none

module mdg_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               req_valid,
    input wire logic               req_ready,
    input wire mdg_pkg::req_word_t req,
    input wire logic               rsp_valid,
    input wire logic               rsp_ready,
    input wire mdg_pkg::rsp_word_t rsp
);

    // a stalled result word holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result word changed while stalled");

    // an error never reports an open cell
    a_err_closed: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status |-> !rsp.cell_open)
        else $error("error result with cell_open set");

    // one word at a time: busy right after an accept
    a_busy_after_acc: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("second word taken while first in work");

    // a new result appears only as the block returns to idle
    a_rsp_at_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> req_ready)
        else $error("result issued while still busy");

endmodule

bind maze_dfs_generator_top mdg_checker u_mdg_checker (.*);

`default_nettype wire

/* tb/maze_dfs_generator_top_tb.sv */
// Testbench for maze_dfs_generator_top: directed and random generate/read words,
// checked against a predictor of the maze walk held in a small scoreboard class.
// Depends on mdg_pkg and the maze_dfs_generator_top RTL.
`timescale 1ns / 1ps

module maze_dfs_generator_top_tb;

    localparam logic REQ_GENERATE = 1'b0;
    localparam logic REQ_READ     = 1'b1;
    localparam int   RANDOM_WORDS = 700;

    class maze_scoreboard;

        typedef struct {
            int            r;
            int            c;
            mdg_pkg::dir_t dirs [4];
            int            nxt;
        } walk_cell_t;

        bit                 grid_q [mdg_pkg::GRID_HEIGHT][mdg_pkg::GRID_WIDTH];
        walk_cell_t         walk_stack [mdg_pkg::STACK_SLOTS];
        int                 walk_depth;
        logic [15:0]        lfsr_q;
        mdg_pkg::rsp_word_t expected_rsp_q [$];
        int                 fail_count;

        function new();
            foreach (grid_q[i, j])
                grid_q[i][j] = 1'b0;
            walk_depth = 0;
            lfsr_q     = 16'h0001;
            fail_count = 0;
        endfunction

        task report_mismatch(input string msg);
            $display("%0t mismatch: %s", $realtime, msg);
            fail_count++;
        endtask

        function int pending();
            return expected_rsp_q.size();
        endfunction

        function bit is_interior(input int r, input int c);
            return r > 0 && r < mdg_pkg::GRID_HEIGHT - 1
                && c > 0 && c < mdg_pkg::GRID_WIDTH - 1;
        endfunction

        // Galois step, shift right; the draw is the low two bits afterwards
        function mdg_pkg::dir_t draw_dir();
            logic out_bit;
            out_bit = lfsr_q[0];
            lfsr_q  = lfsr_q >> 1;
            if (out_bit)
                lfsr_q = lfsr_q ^ mdg_pkg::LFSR_TAPS;
            return mdg_pkg::dir_t'(lfsr_q[1:0]);
        endfunction

        function void enter_cell(input int r, input int c);
            walk_cell_t    frame;
            mdg_pkg::dir_t j;
            mdg_pkg::dir_t t;
            grid_q[r][c] = 1'b1;
            frame.r   = r;
            frame.c   = c;
            frame.nxt = 0;
            for (int i = 0; i < 4; i++)
                frame.dirs[i] = mdg_pkg::dir_t'(i);
            for (int i = 0; i < 4; i++)
            begin
                j = draw_dir();
                t = frame.dirs[i];
                frame.dirs[i] = frame.dirs[j];
                frame.dirs[j] = t;
            end
            if (walk_depth < mdg_pkg::STACK_SLOTS)
            begin
                walk_stack[walk_depth] = frame;
                walk_depth++;
            end
        endfunction

        function void carve_maze(input int r0, input int c0, input logic [15:0] seed);
            int            top;
            int            r;
            int            c;
            int            nr;
            int            nc;
            mdg_pkg::dir_t d;
            foreach (grid_q[i, j])
                grid_q[i][j] = 1'b0;
            lfsr_q     = (seed == 16'h0000) ? 16'h0001 : seed;
            walk_depth = 0;
            enter_cell(r0, c0);
            while (walk_depth > 0)
            begin
                top = walk_depth - 1;
                if (walk_stack[top].nxt >= 4)
                begin
                    walk_depth--;
                end
                else
                begin
                    d  = walk_stack[top].dirs[walk_stack[top].nxt];
                    r  = walk_stack[top].r;
                    c  = walk_stack[top].c;
                    nr = r;
                    nc = c;
                    case (d)
                        mdg_pkg::DIR_RIGHT: nc = c + 2;
                        mdg_pkg::DIR_LEFT:  nc = c - 2;
                        mdg_pkg::DIR_DOWN:  nr = r + 2;
                        default:            nr = r - 2;
                    endcase
                    walk_stack[top].nxt++;
                    if (is_interior(nr, nc) && !grid_q[nr][nc])
                    begin
                        grid_q[(r + nr) / 2][(c + nc) / 2] = 1'b1;
                        enter_cell(nr, nc);
                    end
                end
            end
            grid_q[1][0] = 1'b1;
            grid_q[mdg_pkg::GRID_HEIGHT - 2][mdg_pkg::GRID_WIDTH - 1] = 1'b1;
        endfunction

        function void note_request(input mdg_pkg::req_word_t w);
            mdg_pkg::rsp_word_t exp_rsp;
            int                 r;
            int                 c;
            r = int'(w.row);
            c = int'(w.col);
            exp_rsp = '0;
            if (w.req_type == REQ_GENERATE)
            begin
                if (is_interior(r, c) && r[0] && c[0])
                    carve_maze(r, c, w.seed);
                else
                    exp_rsp.status = 1'b1;
            end
            else
            begin
                if (r < mdg_pkg::GRID_HEIGHT && c < mdg_pkg::GRID_WIDTH)
                    exp_rsp.cell_open = grid_q[r][c];
                else
                    exp_rsp.status = 1'b1;
            end
            expected_rsp_q.push_back(exp_rsp);
        endfunction

        task check_response(input mdg_pkg::rsp_word_t got);
            mdg_pkg::rsp_word_t exp_rsp;
            if (expected_rsp_q.size() == 0)
            begin
                report_mismatch($sformatf("response word %b with none expected", got));
            end
            else
            begin
                exp_rsp = expected_rsp_q.pop_front();
                if (got.cell_open !== exp_rsp.cell_open)
                    report_mismatch($sformatf("cell_open got %b exp %b",
                                              got.cell_open, exp_rsp.cell_open));
                if (got.status !== exp_rsp.status)
                    report_mismatch($sformatf("status got %b exp %b",
                                              got.status, exp_rsp.status));
            end
        endtask

    endclass

    logic               clk;
    logic               rst_n;
    logic               req_valid;
    logic               req_ready;
    mdg_pkg::req_word_t req;
    logic               rsp_valid;
    logic               rsp_ready;
    mdg_pkg::rsp_word_t rsp;

    bit             steady = 1'b0;
    maze_scoreboard sb = new();

    maze_dfs_generator_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic mdg_pkg::req_word_t make_word(input logic kind, input int r,
                                                     input int c, input int s);
        mdg_pkg::req_word_t w;
        w.req_type = kind;
        w.row      = r[mdg_pkg::ROW_W-1:0];
        w.col      = c[mdg_pkg::COL_W-1:0];
        w.seed     = s[mdg_pkg::SEED_W-1:0];
        return w;
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_word(input mdg_pkg::req_word_t w);
        while (!steady && $urandom_range(99) < 13)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= w;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        sb.note_request(w);
        @(negedge clk);
    endtask

    function automatic mdg_pkg::req_word_t random_word();
        int                 pick;
        mdg_pkg::req_word_t w;
        pick = $urandom_range(99);
        w = make_word(REQ_READ, $urandom_range(mdg_pkg::GRID_HEIGHT - 1),
                      $urandom_range(mdg_pkg::GRID_WIDTH - 1), $urandom_range(16'hFFFF));
        if (pick < 6)
        begin
            w.req_type = REQ_GENERATE;
            w.row = mdg_pkg::ROW_W'(2 * $urandom_range((mdg_pkg::GRID_HEIGHT - 3) / 2) + 1);
            w.col = mdg_pkg::COL_W'(2 * $urandom_range((mdg_pkg::GRID_WIDTH - 3) / 2) + 1);
            if ($urandom_range(19) == 0)
                w.seed = '0;
        end
        else if (pick < 8)
        begin
            // start cell anywhere, mostly rejected
            w.req_type = REQ_GENERATE;
            w.row = mdg_pkg::ROW_W'($urandom_range(15));
            w.col = mdg_pkg::COL_W'($urandom_range(15));
        end
        else if (pick < 16)
        begin
            w.row = mdg_pkg::ROW_W'($urandom_range(15));
            w.col = mdg_pkg::COL_W'($urandom_range(15));
        end
        return w;
    endfunction

    initial
    begin
        mdg_pkg::req_word_t directed_q [$];
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        directed_q = '{
            make_word(REQ_READ, 0, 0, 0),
            make_word(REQ_READ, 1, 1, 16'hFFFF),
            make_word(REQ_READ, 15, 15, 0),
            make_word(REQ_READ, 10, 11, 0),
            make_word(REQ_READ, 11, 10, 0),
            make_word(REQ_GENERATE, 0, 1, 16'h1234),
            make_word(REQ_GENERATE, 2, 1, 16'h1234),
            make_word(REQ_GENERATE, 1, 10, 16'h1234),
            make_word(REQ_GENERATE, 11, 1, 16'h1234),
            make_word(REQ_GENERATE, 15, 15, 16'hFFFF),
            make_word(REQ_GENERATE, 1, 1, 0),
            make_word(REQ_READ, 1, 0, 0),
            make_word(REQ_READ, 9, 10, 0),
            make_word(REQ_READ, 1, 1, 0),
            make_word(REQ_READ, 0, 0, 0),
            make_word(REQ_READ, 10, 10, 0),
            make_word(REQ_GENERATE, 9, 9, 16'hFFFF),
            make_word(REQ_READ, 9, 9, 0),
            make_word(REQ_READ, 5, 5, 0),
            make_word(REQ_READ, 2, 1, 0),
            make_word(REQ_GENERATE, 5, 5, 16'h8000),
            make_word(REQ_READ, 5, 6, 0),
            make_word(REQ_READ, 4, 5, 0),
            make_word(REQ_GENERATE, 8, 9, 16'h0001)
        };
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        foreach (directed_q[i])
            send_word(directed_q[i]);
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            steady = (n >= 300 && n < 450);
            send_word(random_word());
        end
        steady = 1'b0;
        req_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (sb.fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        rsp_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_ready <= steady || ($urandom_range(99) >= 13);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            sb.check_response(rsp);
    end

endmodule
